FILE: rtl/acet_pkg.sv
// Shared types, step codes and saturation helpers for the admittance controller.
`timescale 1ns / 1ps
`default_nettype none
package acet_pkg;

	typedef logic [2:0] step_t;

	localparam step_t ST_MUL   = 3'd0;
	localparam step_t ST_NET   = 3'd1;
	localparam step_t ST_ACC   = 3'd2;
	localparam step_t ST_VEL   = 3'd3;
	localparam step_t ST_POS   = 3'd4;
	localparam step_t ST_CLAMP = 3'd5;
	localparam step_t ST_POWER = 3'd6;
	localparam step_t ST_LAST  = ST_POWER;

	typedef struct packed {
		logic  load;
		logic  run;
		step_t step;
		logic  halve;
	} lane_ctrl_t;

	localparam logic [15:0]        INVM_CAP = 16'd25600;
	localparam logic signed [13:0] LEAK_Q16 = 14'sd6554;
	localparam logic signed [39:0] WIDE_MAX = 40'sd549755813887;
	localparam logic signed [39:0] WIDE_MIN = -40'sd549755813887;

	function automatic logic signed [31:0] sat32(input logic signed [41:0] a);
		logic signed [31:0] r;
		if (a > 42'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (a < -42'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = a[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [63:0] a);
		logic signed [39:0] r;
		if (a > 64'(WIDE_MAX)) begin
			r = WIDE_MAX;
		end else if (a < 64'(WIDE_MIN)) begin
			r = WIDE_MIN;
		end else begin
			r = a[39:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/acet_lane.sv
// One axis of the admittance integrator, stepped through its multiply chain.
`timescale 1ns / 1ps
`default_nettype none
module acet_lane import acet_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lane_ctrl_t                 ctrl,
	input  wire logic signed [31:0]         force_in,
	input  wire logic signed [31:0]         ref_in,
	input  wire logic [47:0]                gains,
	input  wire logic [23:0]                step_time,
	input  wire logic [31:0]                deadzone,
	input  wire logic [31:0]                limit,
	output logic signed [31:0]              cmd,
	output logic signed [63-FRAC_BITS:0]    power
);

	localparam int PW = 64 - FRAC_BITS;

	logic signed [31:0] v_q, x_q, f_q, ref_q, vn_q, cmd_q;
	logic signed [48:0] bv_q, kx_q;
	logic signed [39:0] net_q, acc_q;
	logic signed [33:0] xs_q;
	logic signed [PW-1:0] pw_q;

	logic [15:0]        imc;
	logic signed [32:0] fx;
	logic [32:0]        fmag;
	logic signed [31:0] fe;
	logic signed [63:0] net_w;
	logic signed [56:0] accp;
	logic signed [64:0] velp;
	logic signed [56:0] posp;
	logic signed [31:0] xsat;
	logic signed [32:0] lim_s;
	logic signed [63:0] pwp;
	logic signed [24:0] dt_s;

	always_comb begin
		imc   = (gains[15:0] > INVM_CAP) ? INVM_CAP : gains[15:0];
		dt_s  = $signed({1'b0, step_time});
		fx    = 33'(f_q);
		fmag  = fx[32] ? 33'(-fx) : fx;
		fe    = (fmag < {1'b0, deadzone}) ? 32'sd0 : f_q;
		net_w = 64'(fe) - 64'(bv_q >>> 8) - 64'(kx_q >>> 4);
		accp  = 57'(net_q) * 57'($signed({1'b0, imc}));
		velp  = 65'(acc_q) * 65'(dt_s);
		posp  = 57'(vn_q) * 57'(dt_s);
		xsat  = sat32(42'(xs_q));
		lim_s = $signed({1'b0, limit});
		pwp   = 64'(f_q) * 64'(v_q);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			f_q   <= force_in;
			ref_q <= ref_in;
		end
		if (ctrl.run) begin
			case (ctrl.step)
				ST_MUL: begin
					bv_q <= 49'($signed({1'b0, gains[31:16]})) * 49'(v_q);
					kx_q <= 49'($signed({1'b0, gains[47:32]})) * 49'(x_q);
				end
				ST_NET: net_q <= sat40(net_w);
				ST_ACC: acc_q <= sat40(64'(accp >>> 8));
				ST_VEL: vn_q <= sat32(42'(v_q) + 42'(velp >>> 24));
				ST_POS: xs_q <= 34'(x_q) + 34'(posp >>> 24);
				ST_POWER: begin
					cmd_q <= sat32(42'(ref_q) + 42'(x_q));
					pw_q  <= PW'(pwp >>> FRAC_BITS);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			x_q <= '0;
		end else if (ctrl.halve) begin
			v_q <= v_q >>> 1;
		end else if (ctrl.run && ctrl.step == ST_CLAMP) begin
			if (33'(xsat) > lim_s) begin
				x_q <= lim_s[31:0];
				v_q <= (vn_q > 32'sd0) ? 32'sd0 : vn_q;
			end else if (33'(xsat) < -lim_s) begin
				x_q <= 32'(-lim_s);
				v_q <= (vn_q < 32'sd0) ? 32'sd0 : vn_q;
			end else begin
				x_q <= xsat;
				v_q <= vn_q;
			end
		end
	end

	assign cmd   = cmd_q;
	assign power = pw_q;

endmodule
`default_nettype wire

FILE: rtl/acet_tank.sv
// Energy tank: merges the lane power terms and updates the passivity tank.
`timescale 1ns / 1ps
`default_nettype none
module acet_tank import acet_pkg::*; #(
	parameter int AXES      = 6,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [63-FRAC_BITS:0] power [AXES],
	input  wire logic [23:0]             step_time,
	output logic                         done,
	output logic                         halve,
	output logic                         att_flag,
	output logic [31:0]                  level
);

	localparam int PW = 64 - FRAC_BITS;
	localparam int SW = PW + 3;
	localparam int IW = (AXES > 1) ? $clog2(AXES) : 1;

	localparam logic [2:0] TK_IDLE = 3'd0;
	localparam logic [2:0] TK_SUM  = 3'd1;
	localparam logic [2:0] TK_DIFF = 3'd2;
	localparam logic [2:0] TK_MUL  = 3'd3;
	localparam logic [2:0] TK_FIN  = 3'd4;

	logic [2:0]         state_q;
	logic [IW-1:0]      idx_q;
	logic signed [SW-1:0] sum_q;
	logic signed [45:0] leak_q;
	logic signed [39:0] d_q;
	logic signed [41:0] tn_q;
	logic signed [31:0] t_q;
	logic               att_q;
	logic signed [64:0] tp;
	logic signed [41:0] cap;

	always_comb begin
		tp    = 65'(d_q) * 65'($signed({1'b0, step_time}));
		cap   = 42'sd10 <<< FRAC_BITS;
		done  = (state_q == TK_FIN);
		halve = (state_q == TK_FIN) && (tn_q < 42'sd0);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			TK_IDLE: begin
				sum_q  <= '0;
				leak_q <= 46'(t_q) * 46'(LEAK_Q16);
			end
			TK_SUM:  sum_q <= sum_q + SW'(power[idx_q]);
			TK_DIFF: d_q <= sat40(64'(sum_q) - 64'(leak_q >>> 16));
			TK_MUL:  tn_q <= 42'(t_q) + 42'(tp >>> 24);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TK_IDLE;
			idx_q   <= '0;
			t_q     <= '0;
			att_q   <= 1'b0;
		end else begin
			case (state_q)
				TK_IDLE: begin
					idx_q <= '0;
					if (start) begin
						state_q <= TK_SUM;
					end
				end
				TK_SUM: begin
					if (idx_q == IW'(AXES - 1)) begin
						state_q <= TK_DIFF;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				TK_DIFF: state_q <= TK_MUL;
				TK_MUL:  state_q <= TK_FIN;
				TK_FIN: begin
					state_q <= TK_IDLE;
					if (tn_q > cap) begin
						t_q   <= cap[31:0];
						att_q <= 1'b0;
					end else if (tn_q < 42'sd0) begin
						t_q   <= '0;
						att_q <= 1'b1;
					end else begin
						t_q   <= tn_q[31:0];
						att_q <= 1'b0;
					end
				end
				default: state_q <= TK_IDLE;
			endcase
		end
	end

	assign att_flag = att_q;
	assign level    = t_q;

endmodule
`default_nettype wire

FILE: rtl/admittance_control_with_energy_tank.sv
// Six-axis admittance controller with energy-tank passivity guard, top level.
`timescale 1ns / 1ps
`default_nettype none
// One transaction in carries a force and a reference position per axis; one
// transaction out carries the commanded positions, the tank level and the attenuation
// flag. Each axis has its own lane that runs the compliance update in seven steps of
// at most two multiplies each. With passivity enabled the tank then sums the lane power
// terms one axis per cycle and then steps through its difference, multiply and final
// clamp states. A new item is taken only after the previous result has been loaded into
// the output register, and may be taken while that finished result still waits there.
// The user must write gains, step time and limits over the register port only while the
// block is idle; the block itself does not enforce this. Gain registers reset to zero.
module admittance_control_with_energy_tank import acet_pkg::*; #(
	parameter int AXES      = 6,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// force_0..force_{AXES-1}, then ref_0..ref_{AXES-1}, 32 bits each.
	input  wire logic [64*AXES-1:0]         s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// cmd_0..cmd_{AXES-1} 32 bits each, tank_level 20 bits, attenuated, zero pad.
	output logic [((32*AXES+21+7)/8)*8-1:0] m_tdata,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [$clog2(8*(AXES+2))-1:0] paddr,
	input  wire logic [63:0]                pwdata,
	output logic [63:0]                     prdata,
	output logic                            pready
);

	localparam int NREG = AXES + 2;
	localparam int AW   = $clog2(8 * NREG);
	localparam int IW   = AW - 3;
	localparam int ODW  = ((32 * AXES + 21 + 7) / 8) * 8;
	localparam int PW   = 64 - FRAC_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LANE = 2'd1;
	localparam logic [1:0] S_TANK = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [47:0] gains_q [AXES];
	logic [23:0] dt_q;
	logic [32:0] lim_q;

	logic [IW-1:0] idx;
	logic          wr;
	logic [31:0]   deadzone;
	logic [32:0]   lim_wide;
	logic [31:0]   limit;

	logic [1:0]     state_q;
	step_t          step_q;
	logic           m_tvalid_q;
	logic [ODW-1:0] m_tdata_q;
	logic           in_acc;
	logic           tank_start;
	logic           tank_done;
	logic           tank_halve;
	logic           tank_att;
	logic [31:0]    tank_level;
	lane_ctrl_t     lctrl;
	logic           out_load;

	logic signed [31:0]   cmd_w [AXES];
	logic signed [PW-1:0] pw_w  [AXES];

	assign idx    = paddr[AW-1:3];
	assign wr     = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				gains_q[i] <= '0;
			end
			dt_q  <= 24'd16777;
			lim_q <= 33'd7290470;
		end else if (wr) begin
			for (int i = 0; i < AXES; i++) begin
				if (idx == IW'(i)) begin
					gains_q[i] <= pwdata[47:0];
				end
			end
			if (idx == IW'(AXES)) begin
				dt_q <= pwdata[23:0];
			end
			if (idx == IW'(AXES + 1)) begin
				lim_q <= pwdata[32:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < AXES; i++) begin
			if (idx == IW'(i)) begin
				prdata = 64'(gains_q[i]);
			end
		end
		if (idx == IW'(AXES)) begin
			prdata = 64'(dt_q);
		end
		if (idx == IW'(AXES + 1)) begin
			prdata = 64'(lim_q);
		end
	end

	always_comb begin
		deadzone = 32'(lim_q[15:0]) << (FRAC_BITS - 8);
		lim_wide = 33'(lim_q[31:16]) << (FRAC_BITS - 8);
		limit    = (lim_wide > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : lim_wide[31:0];
	end

	assign s_tready   = (state_q == S_IDLE);
	assign in_acc     = s_tvalid && s_tready;
	assign tank_start = (state_q == S_LANE) && (step_q == ST_LAST) && lim_q[32];
	assign out_load   = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		lctrl.load  = in_acc;
		lctrl.run   = (state_q == S_LANE);
		lctrl.step  = step_q;
		lctrl.halve = tank_halve;
	end

	for (genvar g = 0; g < AXES; g++) begin : g_lane
		acet_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (lctrl),
			.force_in  (s_tdata[32*g +: 32]),
			.ref_in    (s_tdata[32*(AXES+g) +: 32]),
			.gains     (gains_q[g]),
			.step_time (dt_q),
			.deadzone  (deadzone),
			.limit     (limit),
			.cmd       (cmd_w[g]),
			.power     (pw_w[g])
		);
	end

	acet_tank #(.AXES(AXES), .FRAC_BITS(FRAC_BITS)) u_tank (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (tank_start),
		.power     (pw_w),
		.step_time (dt_q),
		.done      (tank_done),
		.halve     (tank_halve),
		.att_flag  (tank_att),
		.level     (tank_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= ST_MUL;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					step_q <= ST_MUL;
					if (in_acc) begin
						state_q <= S_LANE;
					end
				end
				S_LANE: begin
					if (step_q == ST_LAST) begin
						state_q <= lim_q[32] ? S_TANK : S_OUT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_TANK: begin
					if (tank_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < AXES; i++) begin
				m_tdata_q[32*i +: 32] <= cmd_w[i];
			end
			m_tdata_q[32*AXES +: 20]       <= tank_level[19:0];
			m_tdata_q[32*AXES + 20]        <= lim_q[32] && tank_att;
			m_tdata_q[ODW-1:32*AXES + 21]  <= '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_LANE) && (step_q == ST_MUL))
		else $error("accepted transaction did not start the lane sequence");

	a_halve_in_tank: assert property (@(posedge clk) disable iff (!arst_n)
		tank_halve |-> (state_q == S_TANK) && tank_done)
		else $error("velocity halving outside the tank update");

	a_tank_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tank_level <= (32'd10 << FRAC_BITS))
		else $error("tank level above its cap");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid && (state_q == S_IDLE))
		else $error("result not presented after completion");

endmodule
`default_nettype wire

FILE: tb/sv/admittance_control_with_energy_tank_test.sv
// Self-checking testbench for the six-axis admittance controller with its energy tank.
`timescale 1ns / 1ps

class tick_scoreboard;
	localparam longint WIDE = 64'sd549755813887;
	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -64'sd2147483648;

	logic [47:0] gains [6];
	logic [23:0] period;
	logic [32:0] lims;
	longint velocity [6];
	longint displacement [6];
	longint tank;
	logic [215:0] pending [$];
	int errors;
	int results;
	int halvings;

	function new();
		foreach (gains[i]) begin
			gains[i] = '0;
			velocity[i] = 0;
			displacement[i] = 0;
		end
		period = 24'd16777;
		lims = 33'd7290470;
		tank = 0;
		errors = 0;
		results = 0;
		halvings = 0;
	endfunction

	function longint clip(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function void write_reg(int idx, logic [63:0] value);
		if (idx < 6) begin
			gains[idx] = value[47:0];
		end else if (idx == 6) begin
			period = value[23:0];
		end else if (idx == 7) begin
			lims = value[32:0];
		end
	endfunction

	function void note(logic [383:0] d);
		longint dt, dz, lim, f, r, fe, im, b, k, v, x, net, acc, power, dlt, cap;
		longint frc [6];
		logic [215:0] e;
		logic att;
		dt = longint'(period);
		dz = longint'(lims[15:0]) <<< 8;
		lim = clip(longint'(lims[31:16]) <<< 8, I32_MIN, I32_MAX);
		att = 1'b0;
		e = '0;
		for (int i = 0; i < 6; i++) begin
			f = longint'($signed(d[32*i +: 32]));
			r = longint'($signed(d[32*(6+i) +: 32]));
			frc[i] = f;
			fe = ((f < 0 ? -f : f) < dz) ? 0 : f;
			im = longint'(gains[i][15:0]);
			if (im > 25600) begin
				im = 25600;
			end
			b = longint'(gains[i][31:16]);
			k = longint'(gains[i][47:32]);
			v = velocity[i];
			x = displacement[i];
			net = clip(fe - ((b * v) >>> 8) - ((k * x) >>> 4), -WIDE, WIDE);
			acc = clip((net * im) >>> 8, -WIDE, WIDE);
			v = clip(v + ((acc * dt) >>> 24), I32_MIN, I32_MAX);
			x = clip(x + ((v * dt) >>> 24), I32_MIN, I32_MAX);
			if (x > lim) begin
				x = lim;
				if (v > 0) v = 0;
			end else if (x < -lim) begin
				x = -lim;
				if (v < 0) v = 0;
			end
			velocity[i] = v;
			displacement[i] = x;
			e[32*i +: 32] = 32'(clip(r + x, I32_MIN, I32_MAX));
		end
		if (lims[32]) begin
			power = 0;
			cap = 64'sd10 <<< 16;
			for (int i = 0; i < 6; i++) begin
				power += (frc[i] * velocity[i]) >>> 16;
			end
			dlt = clip(power - ((tank * 6554) >>> 16), -WIDE, WIDE);
			tank = tank + ((dlt * dt) >>> 24);
			if (tank > cap) tank = cap;
			if (tank < 0) begin
				for (int i = 0; i < 6; i++) begin
					velocity[i] = velocity[i] >>> 1;
				end
				tank = 0;
				att = 1'b1;
				halvings++;
			end
		end
		e[192 +: 20] = tank[19:0];
		e[212] = att;
		pending.push_back(e);
	endfunction

	function void check(logic [215:0] got);
		logic [215:0] e;
		results++;
		if (pending.size() == 0) begin
			$display("%0t: result with none expected, actual %h", $time, got);
			errors++;
			return;
		end
		e = pending.pop_front();
		for (int i = 0; i < 6; i++) begin
			if (got[32*i +: 32] !== e[32*i +: 32]) begin
				$display("%0t: cmd_%0d expected %h actual %h", $time, i,
					e[32*i +: 32], got[32*i +: 32]);
				errors++;
			end
		end
		if (got[192 +: 20] !== e[192 +: 20]) begin
			$display("%0t: tank_level expected %h actual %h", $time, e[192 +: 20],
				got[192 +: 20]);
			errors++;
		end
		if (got[212] !== e[212]) begin
			$display("%0t: attenuated expected %b actual %b", $time, e[212], got[212]);
			errors++;
		end
	endfunction
endclass

module admittance_control_with_energy_tank_test;
	import acet_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [383:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [215:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	tick_scoreboard board = new();
	bit calm = 1'b0;
	bit hold_kick = 1'b0;
	int hold_left = 0;
	int sent = 0;

	admittance_control_with_energy_tank uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) board.note(s_tdata);
		if (arst_n && m_tvalid && m_tready) board.check(m_tdata);
	end

	always @(negedge clk) begin
		if (hold_kick && hold_left == 0) begin
			hold_left = 300;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
			if (hold_left == 0) hold_kick = 1'b0;
		end else begin
			m_tready <= calm || $urandom_range(99) >= 17;
		end
	end

	task automatic write_reg(int idx, logic [63:0] value);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = 6'(8 * idx);
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		board.write_reg(idx, value);
	endtask

	task automatic push_item(logic [383:0] d);
		while (!calm && $urandom_range(99) < 17) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid = 1'b0;
		sent++;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return 32'($signed($urandom_range(4000000)) - 2000000);
		endcase
	endfunction

	function automatic logic [383:0] random_item();
		logic [383:0] d;
		for (int i = 0; i < 12; i++) d[32*i +: 32] = pick_word();
		return d;
	endfunction

	function automatic logic [383:0] uniform_item(logic [31:0] f, logic [31:0] r);
		logic [383:0] d;
		for (int i = 0; i < 6; i++) begin
			d[32*i +: 32] = f;
			d[32*(6+i) +: 32] = r;
		end
		return d;
	endfunction

	task automatic random_setup(int kind);
		logic [47:0] g;
		for (int i = 0; i < 6; i++) begin
			g = {16'($urandom_range(400)), 16'($urandom_range(2000)),
				16'($urandom_range(30000))};
			if (kind == 1) g = '1;
			if (kind == 2) g = '0;
			if (kind == 3) g = 48'({$urandom, $urandom});
			write_reg(i, 64'(g));
		end
		case (kind)
			1: begin
				write_reg(6, 64'hFF_FFFF);
				write_reg(7, 64'h1_FFFF_FFFF);
			end
			2: begin
				write_reg(6, 64'h0);
				write_reg(7, 64'h0);
			end
			default: begin
				write_reg(6, 64'($urandom_range(24'hFF_FFFF, 24'h1000)));
				write_reg(7, {31'h0, 1'($urandom_range(3) != 0),
					16'($urandom), 16'($urandom_range(2000))});
			end
		endcase
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		push_item(uniform_item(32'h0001_0000, 32'h0000_0000));
		push_item(uniform_item(32'h7FFF_FFFF, 32'h7FFF_FFFF));
		drain();
		for (int i = 0; i < 6; i++) write_reg(i, {16'd0, 16'd0, 16'd0, 16'd256});
		write_reg(6, 64'hFF_FFFF);
		write_reg(7, {31'h0, 1'b1, 16'h7FFF, 16'h0100});
		push_item(uniform_item(32'h0000_8000, 32'h0000_1000));
		push_item(uniform_item(32'h0010_0000, 32'h0000_0000));
		push_item(uniform_item(32'h0010_0000, 32'h7FFF_FF00));
		push_item(uniform_item(32'hFFF0_0000, 32'h8000_0000));
		push_item(uniform_item(32'h8000_0000, 32'h8000_0000));
		push_item(uniform_item(32'h7FFF_FFFF, 32'h0000_0000));
		push_item(uniform_item(32'h8000_0000, 32'hFFFF_FFFF));
		drain();
		for (int i = 0; i < 6; i++) write_reg(i, {16'd0, 16'd40, 16'd64, 16'hFFFF});
		write_reg(7, {31'h0, 1'b1, 16'h0001, 16'h0000});
		push_item(uniform_item(32'h0100_0000, 32'h0000_0000));
		push_item(uniform_item(32'hFF00_0000, 32'h7FFF_FFFF));
		push_item(uniform_item(32'h0000_0000, 32'h8000_0000));
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			random_setup(phase == 1 ? 1 : phase == 2 ? 2 : phase == 6 ? 3 : 0);
			calm = (phase == 5);
			for (int n = 0; n < 62; n++) begin
				if (phase == 3 && n == 10) hold_kick = 1'b1;
				push_item(random_item());
			end
			drain();
		end
		calm = 1'b0;

		$display("Covered %0d ticks and %0d results over eleven gain settings,", sent,
			board.results);
		$display("with %0d tank attenuations and a long output back-pressure.",
			board.halvings);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
